// ===== sv/fcaps_pkg.sv =====
// Shared types and constants for the four-channel envelope phase sequencer.
package fcaps_pkg;

  localparam int FRAME_W = 8;
  localparam int MS_W    = 13;
  localparam int FREQ_W  = 16;
  localparam int TIME_W  = 32;

  // Envelope phase of one channel; codes beyond release hold behave as idle.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_A_START = 4'd1,
    PH_A_HOLD  = 4'd2,
    PH_D_START = 4'd3,
    PH_D_HOLD  = 4'd4,
    PH_S_START = 4'd5,
    PH_S_HOLD  = 4'd6,
    PH_R_START = 4'd7,
    PH_R_HOLD  = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ATTACK  = 3'd1,
    EV_DECAY   = 3'd2,
    EV_SUSTAIN = 3'd3,
    EV_RELEASE = 3'd4,
    EV_OFF     = 3'd5
  } event_t;

  localparam logic CMD_TONE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic KIND_SETUP = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Arming request for one channel: load all four counters and restart.
  typedef struct packed {
    logic            en;
    logic [MS_W-1:0] att;
    logic [MS_W-1:0] dec;
    logic [MS_W-1:0] sus;
    logic [MS_W-1:0] rel;
  } arm_t;

endpackage

// ===== sv/four_channel_adsr_phase_sequencer_unit.sv =====
// Top level of the four-channel envelope phase sequencer.
//
// This block sequences the attack, decay, sustain and release phases of up to
// NUM_CHANNELS tone channels and returns exactly one result transaction for
// every input transaction, in order. A tone command (cmd 0) converts the four
// frame-byte lengths to milliseconds as max(frames*1000/60, 1), arms the
// named channel at attack start and reports the set-up. A tick (cmd 1) takes
// the time elapsed since the last stored tick time (zero on the first tick,
// whose time is not stored, so the second tick counts from zero), steps
// every channel and reports one event code per channel for channels 0 to 3.
// The block is a two-stage pipeline: an input register, then one pass of
// conversion and per-channel phase logic that updates the channel state and
// loads the result register on the same edge. An accepted transaction moves
// on once the result register is free or being emptied, and a new one can
// be accepted every cycle as long as the result side does not stall. While
// a finished result waits in the result register the input register still
// takes one more transaction. There are no configuration registers.
module four_channel_adsr_phase_sequencer_unit #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          cmd,
  input  logic [1:0]                    channel,
  input  logic [31:0]                   packed_frequency,
  input  logic [31:0]                   packed_duration,
  input  logic [fcaps_pkg::TIME_W-1:0]  time_ms,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          kind,
  output logic [1:0]                    setup_channel,
  output logic [fcaps_pkg::FREQ_W-1:0]  pitch_hz,
  output logic [fcaps_pkg::FREQ_W-1:0]  cutoff_hz,
  output logic [fcaps_pkg::MS_W-1:0]    attack_len_ms,
  output logic [fcaps_pkg::MS_W-1:0]    decay_len_ms,
  output logic [fcaps_pkg::MS_W-1:0]    release_len_ms,
  output logic [2:0]                    event_ch0,
  output logic [2:0]                    event_ch1,
  output logic [2:0]                    event_ch2,
  output logic [2:0]                    event_ch3
);
  import fcaps_pkg::*;

  localparam int REPORTED = 4;

  // Input register.
  logic              s1_valid;
  logic              s1_cmd;
  logic [1:0]        s1_channel;
  logic [31:0]       s1_freq;
  logic [31:0]       s1_dur;
  logic [TIME_W-1:0] s1_time;

  // Tick timing state.
  logic              first_tick;
  logic [TIME_W-1:0] last_time;
  logic [TIME_W-1:0] delta;

  logic            advance;
  logic            accept;
  logic            is_tick;
  logic [MS_W-1:0] sus_ms, rel_ms, dec_ms, att_ms;
  logic [2:0]      chan_evt [NUM_CHANNELS];
  logic [2:0]      rep_evt [REPORTED];

  // The input register moves on whenever the result register is free or is
  // being emptied in this cycle.
  assign advance    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;
  assign accept     = item_valid && !item_stall;
  assign is_tick    = (s1_cmd == CMD_TICK);

  assign delta = first_tick ? '0 : (s1_time - last_time);

  fcaps_conv u_conv_sus (.frames(s1_dur[7:0]),   .ms(sus_ms));
  fcaps_conv u_conv_rel (.frames(s1_dur[15:8]),  .ms(rel_ms));
  fcaps_conv u_conv_dec (.frames(s1_dur[23:16]), .ms(dec_ms));
  fcaps_conv u_conv_att (.frames(s1_dur[31:24]), .ms(att_ms));

  // One channel sequencer each; a tone command for an index beyond the
  // channel count matches no channel and arms nothing.
  for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_chan
    arm_t arm;
    assign arm.en  = advance && !is_tick && (int'(s1_channel) == k);
    assign arm.att = att_ms;
    assign arm.dec = dec_ms;
    assign arm.sus = sus_ms;
    assign arm.rel = rel_ms;

    fcaps_chan u_chan (
      .clk  (clk),
      .rst  (rst),
      .arm  (arm),
      .tick (advance && is_tick),
      .delta(delta),
      .evt  (chan_evt[k])
    );
  end

  // Only the first four channels have an event field.
  for (genvar k = 0; k < REPORTED; k++) begin : g_rep
    if (k < NUM_CHANNELS) begin : g_on
      assign rep_evt[k] = chan_evt[k];
    end else begin : g_off
      assign rep_evt[k] = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      first_tick   <= 1'b1;
      last_time    <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      // The first tick only clears the flag and leaves last_time alone.
      if (advance && is_tick) begin
        if (first_tick) begin
          first_tick <= 1'b0;
        end else begin
          last_time <= s1_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd     <= cmd;
      s1_channel <= channel;
      s1_freq    <= packed_frequency;
      s1_dur     <= packed_duration;
      s1_time    <= time_ms;
    end
  end

  // Result register: fields that do not belong to the report kind are zero.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (is_tick) begin
        kind           <= KIND_TICK;
        setup_channel  <= '0;
        pitch_hz       <= '0;
        cutoff_hz      <= '0;
        attack_len_ms  <= '0;
        decay_len_ms   <= '0;
        release_len_ms <= '0;
        event_ch0      <= rep_evt[0];
        event_ch1      <= rep_evt[1];
        event_ch2      <= rep_evt[2];
        event_ch3      <= rep_evt[3];
      end else begin
        kind           <= KIND_SETUP;
        setup_channel  <= s1_channel;
        pitch_hz       <= s1_freq[15:0];
        cutoff_hz      <= s1_freq[31:16];
        attack_len_ms  <= att_ms;
        decay_len_ms   <= dec_ms;
        release_len_ms <= rel_ms;
        event_ch0      <= EV_NONE;
        event_ch1      <= EV_NONE;
        event_ch2      <= EV_NONE;
        event_ch3      <= EV_NONE;
      end
    end
  end

  // A tick report never carries set-up data.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_TICK) |->
      (setup_channel == '0 && pitch_hz == '0 && cutoff_hz == '0 &&
       attack_len_ms == '0 && decay_len_ms == '0 && release_len_ms == '0))
    else $error("tick report carries set-up fields");

  // A set-up report carries no events and only nonzero lengths.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_SETUP) |->
      (event_ch0 == EV_NONE && event_ch1 == EV_NONE && event_ch2 == EV_NONE &&
       event_ch3 == EV_NONE && attack_len_ms != '0 && decay_len_ms != '0 &&
       release_len_ms != '0))
    else $error("set-up report has events or a zero length");

  // Any tick that passes through the pipeline ends the first-tick window.
  assert property (@(posedge clk) disable iff (rst)
    (advance && is_tick) |=> !first_tick)
    else $error("first tick flag survived a tick");

  // Every transaction leaving the input register lands in the result register.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("result lost after input register advanced");

endmodule

// ===== sv/fcaps_conv.sv =====
// Frame count to millisecond conversion, max(frames * 1000 / 60, 1).
module fcaps_conv (
  input  logic [fcaps_pkg::FRAME_W-1:0] frames,
  output logic [fcaps_pkg::MS_W-1:0]    ms
);
  import fcaps_pkg::*;

  // 1000/60 reduces to 50/3; the division by three uses a reciprocal that is
  // exact for every value below 2^16.
  localparam int SCALED_W = FRAME_W + 6;
  localparam int RECIP_SH = 17;
  localparam logic [RECIP_SH-1:0] RECIP3 = 17'd43691;

  logic [SCALED_W-1:0]          scaled;
  logic [SCALED_W+RECIP_SH-1:0] prod;
  logic [MS_W-1:0]              quot;

  // frames * 50 as shifts and adds.
  assign scaled = ({6'd0, frames} << 5) + ({6'd0, frames} << 4) + ({6'd0, frames} << 1);
  assign prod   = {{RECIP_SH{1'b0}}, scaled} * {{SCALED_W{1'b0}}, RECIP3};
  assign quot   = prod[RECIP_SH +: MS_W];
  assign ms     = (quot == '0) ? MS_W'(1) : quot;

endmodule

// ===== sv/fcaps_chan.sv =====
// Envelope phase state and per-tick phase stepping for one tone channel.
module fcaps_chan (
  input  logic                         clk,
  input  logic                         rst,
  input  fcaps_pkg::arm_t              arm,
  input  logic                         tick,
  input  logic [fcaps_pkg::TIME_W-1:0] delta,
  output logic [2:0]                   evt
);
  import fcaps_pkg::*;

  phase_t          phase, phase_next;
  logic [MS_W-1:0] attack_left, attack_left_next;
  logic [MS_W-1:0] decay_left, decay_left_next;
  logic [MS_W-1:0] sustain_left, sustain_left_next;
  logic [MS_W-1:0] release_left, release_left_next;
  event_t          ev;
  logic            a_exp, d_exp, s_exp, r_exp;

  // A hold counter expires when the elapsed time reaches what is left.
  assign a_exp = {{(TIME_W-MS_W){1'b0}}, attack_left}  <= delta;
  assign d_exp = {{(TIME_W-MS_W){1'b0}}, decay_left}   <= delta;
  assign s_exp = {{(TIME_W-MS_W){1'b0}}, sustain_left} <= delta;
  assign r_exp = {{(TIME_W-MS_W){1'b0}}, release_left} <= delta;

  // Next state; an expired hold goes on at once, skipping the next start phase.
  always_comb begin
    phase_next        = phase;
    attack_left_next  = attack_left;
    decay_left_next   = decay_left;
    sustain_left_next = sustain_left;
    release_left_next = release_left;
    if (arm.en) begin
      phase_next        = PH_A_START;
      attack_left_next  = arm.att;
      decay_left_next   = arm.dec;
      sustain_left_next = arm.sus;
      release_left_next = arm.rel;
    end else if (tick) begin
      case (phase)
        PH_A_START: begin
          phase_next = (attack_left == '0) ? PH_D_START : PH_A_HOLD;
        end
        PH_A_HOLD: begin
          if (!a_exp) begin
            attack_left_next = attack_left - delta[MS_W-1:0];
          end else begin
            attack_left_next = '0;
            phase_next = (decay_left == '0) ? PH_S_START : PH_D_HOLD;
          end
        end
        PH_D_START: begin
          phase_next = (decay_left == '0) ? PH_S_START : PH_D_HOLD;
        end
        PH_D_HOLD: begin
          if (!d_exp) begin
            decay_left_next = decay_left - delta[MS_W-1:0];
          end else begin
            decay_left_next = '0;
            phase_next = (sustain_left == '0) ? PH_R_START : PH_S_HOLD;
          end
        end
        PH_S_START: begin
          phase_next = (sustain_left == '0) ? PH_R_START : PH_S_HOLD;
        end
        PH_S_HOLD: begin
          if (!s_exp) begin
            sustain_left_next = sustain_left - delta[MS_W-1:0];
          end else begin
            sustain_left_next = '0;
            phase_next = (release_left == '0) ? PH_IDLE : PH_R_HOLD;
          end
        end
        PH_R_START: begin
          phase_next = (release_left == '0) ? PH_IDLE : PH_R_HOLD;
        end
        PH_R_HOLD: begin
          if (!r_exp) begin
            release_left_next = release_left - delta[MS_W-1:0];
          end else begin
            release_left_next = '0;
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Event reported for this tick.
  always_comb begin
    ev = EV_NONE;
    case (phase)
      PH_A_START: ev = (attack_left == '0) ? EV_NONE : EV_ATTACK;
      PH_A_HOLD: begin
        if (a_exp) begin
          ev = (decay_left == '0) ? EV_NONE : EV_DECAY;
        end
      end
      PH_D_START: ev = (decay_left == '0) ? EV_NONE : EV_DECAY;
      PH_D_HOLD: begin
        if (d_exp) begin
          ev = (sustain_left == '0) ? EV_NONE : EV_SUSTAIN;
        end
      end
      PH_S_START: ev = (sustain_left == '0) ? EV_NONE : EV_SUSTAIN;
      PH_S_HOLD: begin
        if (s_exp) begin
          ev = (release_left == '0) ? EV_OFF : EV_RELEASE;
        end
      end
      PH_R_START: ev = (release_left == '0) ? EV_OFF : EV_RELEASE;
      PH_R_HOLD: begin
        if (r_exp) begin
          ev = EV_OFF;
        end
      end
      default: ev = EV_NONE;
    endcase
  end

  assign evt = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      attack_left  <= '0;
      decay_left   <= '0;
      sustain_left <= '0;
      release_left <= '0;
    end else begin
      phase        <= phase_next;
      attack_left  <= attack_left_next;
      decay_left   <= decay_left_next;
      sustain_left <= sustain_left_next;
      release_left <= release_left_next;
    end
  end

endmodule
